### rtl/core/rgmi_pkg.sv
// rgmi_pkg: shared types and codes of the rectilinear grid interpolator
// holds result codes, action codes, register indexes, controller states and the
// command and status structs between controller and datapath; no dependencies
package rgmi_pkg;

	// result status codes
	typedef enum logic [1:0] {
		RES_OK         = 2'd0,
		RES_OUTSIDE    = 2'd1,
		RES_ZERO_WIDTH = 2'd2
	} res_t;

	// input word action codes
	localparam logic [1:0] ACT_LOAD_COORD = 2'd0;
	localparam logic [1:0] ACT_LOAD_NODE  = 2'd1;
	localparam logic [1:0] ACT_QUERY      = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_NUM_DIMS  = 2'd0;
	localparam logic [1:0] CFG_LEN_AXIS0 = 2'd1;
	localparam logic [1:0] CFG_LEN_AXIS1 = 2'd2;
	localparam logic [1:0] CFG_LEN_AXIS2 = 2'd3;

	// fixed sizes
	localparam int USE_DIMS   = 3;
	localparam int NODE_DEPTH = 4096;
	localparam int NODE_AW    = 12;
	localparam int DIV_BITS   = 18;
	localparam logic [16:0] T_ONE = 17'd65536;

	// controller states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_AX_INIT,
		ST_AX_LO,
		ST_AX_HI,
		ST_MID_RD,
		ST_MID_CMP,
		ST_AX_NEXT,
		ST_ZW_CHK,
		ST_DIV_INIT,
		ST_DIV_STEP,
		ST_DIV_END,
		ST_STRIDE,
		ST_FETCH_ADR,
		ST_FETCH_RD,
		ST_PUSH,
		ST_LERP_MUL,
		ST_LERP_ADD,
		ST_DONE
	} state_t;

	// datapath operations
	typedef enum logic [4:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_AX_INIT,
		OP_AX_LO,
		OP_AX_HI,
		OP_MID_RD,
		OP_MID_CMP,
		OP_AX_NEXT,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_DIV_END,
		OP_STRIDE,
		OP_FETCH_ADR,
		OP_FETCH_RD,
		OP_PUSH,
		OP_LERP_MUL,
		OP_LERP_ADD,
		OP_PUBLISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		res_t   res;
	} dp_cmd_t;

	typedef struct packed {
		logic outside;
		logic adjacent;
		logic ax_last;
		logic zero_width;
		logic div_last;
		logic corner_last;
		logic queue_done;
	} dp_stat_t;

endpackage

### rtl/core/rgmi_dp.sv
// rgmi_dp: datapath of the grid interpolator
// holds config registers, coordinate and node memories, search, divider and lerp unit
// depends on rgmi_pkg
module rgmi_dp #(
	parameter int MAX_DIMS    = 3,
	parameter int AXIS_POINTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [4:0]          cfg_data,
	input  logic [1:0]          action,
	input  logic [1:0]          axis_sel,
	input  logic [11:0]         entry_index,
	input  logic signed [31:0]  load_data,
	input  logic signed [31:0]  point_0,
	input  logic signed [31:0]  point_1,
	input  logic signed [31:0]  point_2,
	input  rgmi_pkg::dp_cmd_t   cmd,
	output rgmi_pkg::dp_stat_t  stat,
	output logic signed [31:0]  interp_value,
	output logic [1:0]          status
);

	localparam int LW     = $clog2(AXIS_POINTS + 1);
	localparam int PW     = $clog2(AXIS_POINTS);
	localparam int CDEPTH = MAX_DIMS * AXIS_POINTS;
	localparam int CAW    = $clog2(CDEPTH);
	localparam int DMAX   = (MAX_DIMS < rgmi_pkg::USE_DIMS) ? MAX_DIMS : rgmi_pkg::USE_DIMS;
	localparam int CW     = (LW > 5) ? LW : 5;
	localparam int FW0    = PW + 1 + 2 * LW + 2;
	localparam int FW     = (FW0 > 13) ? FW0 : 13;

	// config registers
	logic [1:0] dims_q;
	logic [4:0] len_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q   <= 2'd1;
			len_q[0] <= 5'd16;
			len_q[1] <= 5'd16;
			len_q[2] <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				rgmi_pkg::CFG_NUM_DIMS:  dims_q   <= cfg_data[1:0];
				rgmi_pkg::CFG_LEN_AXIS0: len_q[0] <= cfg_data;
				rgmi_pkg::CFG_LEN_AXIS1: len_q[1] <= cfg_data;
				rgmi_pkg::CFG_LEN_AXIS2: len_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped config values
	logic [1:0]    dims_eff;
	logic [LW-1:0] len_eff [3];

	always_comb begin
		if (dims_q == 2'd0)
			dims_eff = 2'd1;
		else if (int'(dims_q) > DMAX)
			dims_eff = 2'(DMAX);
		else
			dims_eff = dims_q;
		for (int d = 0; d < 3; d++) begin
			if (len_q[d] < 5'd2)
				len_eff[d] = LW'(2);
			else if (int'(len_q[d]) > AXIS_POINTS)
				len_eff[d] = LW'(AXIS_POINTS);
			else
				len_eff[d] = LW'(CW'(len_q[d]));
		end
	end

	// control registers
	logic [1:0]  ax_q;
	logic [4:0]  cnt_q;
	logic [2:0]  j_q;
	logic [3:0]  nq_q;
	logic [1:0]  lax_q;
	logic [2:0]  lcnt_q;

	// payload registers
	logic signed [31:0] pt_q [3];
	logic [PW-1:0]      lo_q, hi_q, mid_q;
	logic signed [31:0] clo_q, chi_q;
	logic [PW-1:0]      pos_q [3];
	logic signed [31:0] x0_q [3];
	logic signed [31:0] x1_q [3];
	logic [32:0]        rem_q, den_q;
	logic [17:0]        nlo_q, quo_q;
	logic               neg_q, big_q;
	logic [16:0]        t_q [3];
	logic [2*LW-1:0]    s0_q;
	logic [LW-1:0]      s1_q;
	logic [rgmi_pkg::NODE_AW-1:0] naddr_q;
	logic               noob_q;
	logic signed [31:0] q_q [8];
	logic signed [31:0] a_q;
	logic signed [50:0] prod_q;
	logic signed [31:0] val_q;
	logic [1:0]         res_q;

	// coordinate memory
	logic signed [31:0] coord_mem [CDEPTH];
	logic signed [31:0] crd_q;
	logic               coord_we, coord_re;
	logic [CAW-1:0]     cwaddr, craddr;
	logic [PW-1:0]      rd_idx;
	logic [PW:0]        mid_sum;

	assign mid_sum  = (PW+1)'(lo_q) + (PW+1)'(hi_q);
	assign coord_we = (cmd.op == rgmi_pkg::OP_ACCEPT) && (action == rgmi_pkg::ACT_LOAD_COORD)
		&& (int'(axis_sel) < MAX_DIMS) && (int'(entry_index) < AXIS_POINTS);
	assign cwaddr   = CAW'(int'(axis_sel) * AXIS_POINTS + int'(entry_index));
	assign coord_re = (cmd.op == rgmi_pkg::OP_AX_INIT) || (cmd.op == rgmi_pkg::OP_AX_LO)
		|| (cmd.op == rgmi_pkg::OP_MID_RD);

	always_comb begin
		case (cmd.op)
			rgmi_pkg::OP_AX_LO:  rd_idx = hi_q;
			rgmi_pkg::OP_MID_RD: rd_idx = mid_sum[PW:1];
			default:             rd_idx = '0;
		endcase
	end

	assign craddr = CAW'(int'(ax_q) * AXIS_POINTS + int'(rd_idx));

	always_ff @(posedge clk) begin
		if (coord_we)
			coord_mem[cwaddr] <= load_data;
		if (coord_re)
			crd_q <= coord_mem[craddr];
	end

	// node memory
	logic signed [31:0] node_mem [rgmi_pkg::NODE_DEPTH];
	logic signed [31:0] nrd_q;

	always_ff @(posedge clk) begin
		if ((cmd.op == rgmi_pkg::OP_ACCEPT) && (action == rgmi_pkg::ACT_LOAD_NODE))
			node_mem[entry_index] <= load_data;
		if (cmd.op == rgmi_pkg::OP_FETCH_RD)
			nrd_q <= node_mem[naddr_q];
	end

	// search compare and division setup
	logic signed [31:0] pt_cur;
	logic signed [32:0] num_s, den_s;
	logic [32:0]        n_mag, d_mag;
	logic [33:0]        trial;
	logic               ge;

	assign pt_cur = pt_q[ax_q];
	assign num_s  = 33'(pt_cur) - 33'(x0_q[ax_q]);
	assign den_s  = 33'(x1_q[ax_q]) - 33'(x0_q[ax_q]);
	assign n_mag  = num_s[32] ? 33'(-num_s) : 33'(num_s);
	assign d_mag  = den_s[32] ? 33'(-den_s) : 33'(den_s);
	assign trial  = {rem_q, nlo_q[17]} - {1'b0, den_q};
	assign ge     = !trial[33];

	// corner address
	logic       off [3];
	logic [PW:0] idx [3];
	logic [FW-1:0] flat;

	always_comb begin
		off[0] = 1'b0;
		off[1] = 1'b0;
		off[2] = 1'b0;
		case (dims_eff)
			2'd2: begin
				off[0] = j_q[1];
				off[1] = j_q[0];
			end
			2'd3: begin
				off[0] = j_q[2];
				off[1] = j_q[1];
				off[2] = j_q[0];
			end
			default: off[0] = j_q[0];
		endcase
		for (int d = 0; d < 3; d++)
			idx[d] = (d < int'(dims_eff)) ? ((PW+1)'(pos_q[d]) + (PW+1)'(off[d])) : '0;
		flat = FW'(idx[0]) * FW'(s0_q) + FW'(idx[1]) * FW'(s1_q) + FW'(idx[2]);
	end

	// lerp arithmetic
	logic signed [32:0] diff;
	logic signed [50:0] prod_w, rnd;
	logic signed [35:0] sum;
	logic signed [31:0] sat;

	assign diff   = 33'(q_q[1]) - 33'(q_q[0]);
	assign prod_w = 51'(diff) * 51'($signed({1'b0, t_q[lax_q]}));
	assign rnd    = prod_q + 51'sd32768;
	assign sum    = 36'(a_q) + 36'($signed(rnd[50:16]));

	always_comb begin
		if (sum > 36'sd2147483647)
			sat = 32'sh7fffffff;
		else if (sum < -36'sd2147483648)
			sat = 32'sh80000000;
		else
			sat = sum[31:0];
	end

	// status to controller
	logic [2:0] corner_max;

	always_comb begin
		case (dims_eff)
			2'd2:    corner_max = 3'd3;
			2'd3:    corner_max = 3'd7;
			default: corner_max = 3'd1;
		endcase
		stat.outside     = (pt_cur < clo_q) || (pt_cur > crd_q);
		stat.adjacent    = (PW+1)'(hi_q) == ((PW+1)'(lo_q) + (PW+1)'(1));
		stat.ax_last     = (ax_q == 2'(dims_eff - 2'd1));
		stat.zero_width  = 1'b0;
		for (int d = 0; d < 3; d++)
			if ((d < int'(dims_eff)) && (x0_q[d] == x1_q[d]))
				stat.zero_width = 1'b1;
		stat.div_last    = (cnt_q == 5'd1);
		stat.corner_last = (j_q == corner_max);
		stat.queue_done  = (nq_q == 4'd1);
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q   <= '0;
			cnt_q  <= '0;
			j_q    <= '0;
			nq_q   <= '0;
			lax_q  <= '0;
			lcnt_q <= '0;
		end else begin
			case (cmd.op)
				rgmi_pkg::OP_ACCEPT: ax_q <= '0;
				rgmi_pkg::OP_AX_NEXT, rgmi_pkg::OP_DIV_END:
					ax_q <= stat.ax_last ? 2'd0 : ax_q + 2'd1;
				rgmi_pkg::OP_DIV_INIT: cnt_q <= 5'(rgmi_pkg::DIV_BITS);
				rgmi_pkg::OP_DIV_STEP: cnt_q <= cnt_q - 5'd1;
				rgmi_pkg::OP_STRIDE: begin
					j_q   <= '0;
					nq_q  <= '0;
					lax_q <= dims_eff - 2'd1;
					case (dims_eff)
						2'd2:    lcnt_q <= 3'd2;
						2'd3:    lcnt_q <= 3'd4;
						default: lcnt_q <= 3'd1;
					endcase
				end
				rgmi_pkg::OP_PUSH: begin
					j_q  <= j_q + 3'd1;
					nq_q <= nq_q + 4'd1;
				end
				rgmi_pkg::OP_LERP_MUL: begin
					nq_q <= nq_q - 4'd2;
					if (lcnt_q == 3'd1) begin
						lax_q  <= lax_q - 2'd1;
						lcnt_q <= 3'd1 << (lax_q - 2'd1);
					end else begin
						lcnt_q <= lcnt_q - 3'd1;
					end
				end
				rgmi_pkg::OP_LERP_ADD: nq_q <= nq_q + 4'd1;
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			rgmi_pkg::OP_ACCEPT: begin
				pt_q[0] <= point_0;
				pt_q[1] <= point_1;
				pt_q[2] <= point_2;
			end
			rgmi_pkg::OP_AX_INIT: begin
				lo_q <= '0;
				hi_q <= PW'(len_eff[ax_q] - LW'(1));
			end
			rgmi_pkg::OP_AX_LO: clo_q <= crd_q;
			rgmi_pkg::OP_AX_HI: chi_q <= crd_q;
			rgmi_pkg::OP_MID_RD: mid_q <= mid_sum[PW:1];
			rgmi_pkg::OP_MID_CMP: begin
				if (pt_cur > crd_q) begin
					lo_q  <= mid_q;
					clo_q <= crd_q;
				end else begin
					hi_q  <= mid_q;
					chi_q <= crd_q;
				end
			end
			rgmi_pkg::OP_AX_NEXT: begin
				pos_q[ax_q] <= lo_q;
				x0_q[ax_q]  <= clo_q;
				x1_q[ax_q]  <= chi_q;
			end
			rgmi_pkg::OP_DIV_INIT: begin
				rem_q <= 33'(n_mag[32:2]);
				nlo_q <= {n_mag[1:0], 16'd0};
				den_q <= d_mag;
				quo_q <= '0;
				neg_q <= num_s[32] ^ den_s[32];
				big_q <= 33'(n_mag[32:2]) >= d_mag;
			end
			rgmi_pkg::OP_DIV_STEP: begin
				rem_q <= ge ? trial[32:0] : {rem_q[31:0], nlo_q[17]};
				nlo_q <= {nlo_q[16:0], 1'b0};
				quo_q <= {quo_q[16:0], ge};
			end
			rgmi_pkg::OP_DIV_END: begin
				if (neg_q)
					t_q[ax_q] <= '0;
				else if (big_q || (quo_q > 18'(rgmi_pkg::T_ONE)))
					t_q[ax_q] <= rgmi_pkg::T_ONE;
				else
					t_q[ax_q] <= quo_q[16:0];
			end
			rgmi_pkg::OP_STRIDE: begin
				case (dims_eff)
					2'd2: begin
						s0_q <= (2*LW)'(len_eff[1]);
						s1_q <= LW'(1);
					end
					2'd3: begin
						s0_q <= (2*LW)'(len_eff[1]) * (2*LW)'(len_eff[2]);
						s1_q <= len_eff[2];
					end
					default: begin
						s0_q <= (2*LW)'(1);
						s1_q <= LW'(1);
					end
				endcase
			end
			rgmi_pkg::OP_FETCH_ADR: begin
				naddr_q <= flat[rgmi_pkg::NODE_AW-1:0];
				noob_q  <= (flat[FW-1:rgmi_pkg::NODE_AW] != '0);
			end
			rgmi_pkg::OP_PUSH: q_q[nq_q[2:0]] <= noob_q ? 32'sd0 : nrd_q;
			rgmi_pkg::OP_LERP_MUL: begin
				a_q    <= q_q[0];
				prod_q <= prod_w;
				for (int i = 0; i < 6; i++)
					q_q[i] <= q_q[i+2];
			end
			rgmi_pkg::OP_LERP_ADD: q_q[nq_q[2:0]] <= sat;
			rgmi_pkg::OP_PUBLISH: begin
				val_q <= (cmd.res == rgmi_pkg::RES_OK) ? q_q[0] : 32'sd0;
				res_q <= cmd.res;
			end
			default: ;
		endcase
	end

	assign interp_value = val_q;
	assign status       = res_q;

endmodule

### rtl/core/rgmi_ctrl.sv
// rgmi_ctrl: sequencer of the grid interpolator
// steps search, division, corner fetch and lerp, owns the result valid flag
// depends on rgmi_pkg
module rgmi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         action,
	output logic               in_ready,
	input  logic               out_ready,
	output logic               out_valid,
	input  rgmi_pkg::dp_stat_t stat,
	output rgmi_pkg::dp_cmd_t  cmd
);

	rgmi_pkg::state_t state_q, state_d;
	rgmi_pkg::res_t   res_q, res_d;
	logic             out_valid_q;
	logic             publish;

	// next state
	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		case (state_q)
			rgmi_pkg::ST_IDLE:
				if (in_valid && (action == rgmi_pkg::ACT_QUERY))
					state_d = rgmi_pkg::ST_AX_INIT;
			rgmi_pkg::ST_AX_INIT: state_d = rgmi_pkg::ST_AX_LO;
			rgmi_pkg::ST_AX_LO:   state_d = rgmi_pkg::ST_AX_HI;
			rgmi_pkg::ST_AX_HI: begin
				if (stat.outside) begin
					state_d = rgmi_pkg::ST_DONE;
					res_d   = rgmi_pkg::RES_OUTSIDE;
				end else begin
					state_d = rgmi_pkg::ST_MID_RD;
				end
			end
			rgmi_pkg::ST_MID_RD:
				state_d = stat.adjacent ? rgmi_pkg::ST_AX_NEXT : rgmi_pkg::ST_MID_CMP;
			rgmi_pkg::ST_MID_CMP: state_d = rgmi_pkg::ST_MID_RD;
			rgmi_pkg::ST_AX_NEXT:
				state_d = stat.ax_last ? rgmi_pkg::ST_ZW_CHK : rgmi_pkg::ST_AX_INIT;
			rgmi_pkg::ST_ZW_CHK: begin
				if (stat.zero_width) begin
					state_d = rgmi_pkg::ST_DONE;
					res_d   = rgmi_pkg::RES_ZERO_WIDTH;
				end else begin
					state_d = rgmi_pkg::ST_DIV_INIT;
				end
			end
			rgmi_pkg::ST_DIV_INIT: state_d = rgmi_pkg::ST_DIV_STEP;
			rgmi_pkg::ST_DIV_STEP:
				if (stat.div_last)
					state_d = rgmi_pkg::ST_DIV_END;
			rgmi_pkg::ST_DIV_END:
				state_d = stat.ax_last ? rgmi_pkg::ST_STRIDE : rgmi_pkg::ST_DIV_INIT;
			rgmi_pkg::ST_STRIDE:    state_d = rgmi_pkg::ST_FETCH_ADR;
			rgmi_pkg::ST_FETCH_ADR: state_d = rgmi_pkg::ST_FETCH_RD;
			rgmi_pkg::ST_FETCH_RD:  state_d = rgmi_pkg::ST_PUSH;
			rgmi_pkg::ST_PUSH:
				state_d = stat.corner_last ? rgmi_pkg::ST_LERP_MUL : rgmi_pkg::ST_FETCH_ADR;
			rgmi_pkg::ST_LERP_MUL: begin
				if (stat.queue_done) begin
					state_d = rgmi_pkg::ST_DONE;
					res_d   = rgmi_pkg::RES_OK;
				end else begin
					state_d = rgmi_pkg::ST_LERP_ADD;
				end
			end
			rgmi_pkg::ST_LERP_ADD: state_d = rgmi_pkg::ST_LERP_MUL;
			rgmi_pkg::ST_DONE:
				if (!out_valid_q || out_ready)
					state_d = rgmi_pkg::ST_IDLE;
			default: state_d = rgmi_pkg::ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd.op   = rgmi_pkg::OP_NOP;
		cmd.res  = res_q;
		in_ready = 1'b0;
		publish  = 1'b0;
		case (state_q)
			rgmi_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					cmd.op = rgmi_pkg::OP_ACCEPT;
			end
			rgmi_pkg::ST_AX_INIT: cmd.op = rgmi_pkg::OP_AX_INIT;
			rgmi_pkg::ST_AX_LO:   cmd.op = rgmi_pkg::OP_AX_LO;
			rgmi_pkg::ST_AX_HI:   cmd.op = rgmi_pkg::OP_AX_HI;
			rgmi_pkg::ST_MID_RD:
				if (!stat.adjacent)
					cmd.op = rgmi_pkg::OP_MID_RD;
			rgmi_pkg::ST_MID_CMP:   cmd.op = rgmi_pkg::OP_MID_CMP;
			rgmi_pkg::ST_AX_NEXT:   cmd.op = rgmi_pkg::OP_AX_NEXT;
			rgmi_pkg::ST_DIV_INIT:  cmd.op = rgmi_pkg::OP_DIV_INIT;
			rgmi_pkg::ST_DIV_STEP:  cmd.op = rgmi_pkg::OP_DIV_STEP;
			rgmi_pkg::ST_DIV_END:   cmd.op = rgmi_pkg::OP_DIV_END;
			rgmi_pkg::ST_STRIDE:    cmd.op = rgmi_pkg::OP_STRIDE;
			rgmi_pkg::ST_FETCH_ADR: cmd.op = rgmi_pkg::OP_FETCH_ADR;
			rgmi_pkg::ST_FETCH_RD:  cmd.op = rgmi_pkg::OP_FETCH_RD;
			rgmi_pkg::ST_PUSH:      cmd.op = rgmi_pkg::OP_PUSH;
			rgmi_pkg::ST_LERP_MUL:
				if (!stat.queue_done)
					cmd.op = rgmi_pkg::OP_LERP_MUL;
			rgmi_pkg::ST_LERP_ADD: cmd.op = rgmi_pkg::OP_LERP_ADD;
			rgmi_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = rgmi_pkg::OP_PUBLISH;
					publish = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// state and result valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rgmi_pkg::ST_IDLE;
			res_q       <= rgmi_pkg::RES_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (publish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/core/rectilinear_grid_multilinear_interp.sv
// rectilinear_grid_multilinear_interp: top level of the grid interpolator
// joins the sequencer rgmi_ctrl and the datapath rgmi_dp; depends on rgmi_pkg
//
// channel  direction  handshake             word
// cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
// in       in         in_valid/in_ready     action, axis_sel, entry_index, load_data, point_0..2
// out      out        out_valid/out_ready   interp_value, status
//
// a load word leaves the core ready for the next word; a query runs per axis a search
// on the single coordinate memory port, then per axis the one-bit-a-cycle divider,
// then a fetch per corner on the node memory port and the lerps; an outside-grid
// result ends at the end-point check of its axis, before its interval search
// reset clears control state and the config registers; memories hold nothing defined until written
// the result register frees the core, so words are taken while a result waits;
// a finished query waits for the result register to drain before the next word
module rectilinear_grid_multilinear_interp #(
	parameter int MAX_DIMS    = 3,
	parameter int AXIS_POINTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [4:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [1:0]         axis_sel,
	input  logic [11:0]        entry_index,
	input  logic signed [31:0] load_data,
	input  logic signed [31:0] point_0,
	input  logic signed [31:0] point_1,
	input  logic signed [31:0] point_2,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] interp_value,
	output logic [1:0]         status
);

	rgmi_pkg::dp_cmd_t  cmd;
	rgmi_pkg::dp_stat_t stat;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	// sequencer
	rgmi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.action    (action),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath
	rgmi_dp #(
		.MAX_DIMS    (MAX_DIMS),
		.AXIS_POINTS (AXIS_POINTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.action       (action),
		.axis_sel     (axis_sel),
		.entry_index  (entry_index),
		.load_data    (load_data),
		.point_0      (point_0),
		.point_1      (point_1),
		.point_2      (point_2),
		.cmd          (cmd),
		.stat         (stat),
		.interp_value (interp_value),
		.status       (status)
	);

`ifndef SYNTH
	// error results carry a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != 2'(rgmi_pkg::RES_OK)) |-> interp_value == 32'sd0)
		else $error("error result with nonzero value");

	// status code stays in the defined set
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == 2'(rgmi_pkg::RES_OK)) || (status == 2'(rgmi_pkg::RES_OUTSIDE))
			|| (status == 2'(rgmi_pkg::RES_ZERO_WIDTH)))
		else $error("undefined status code");

	// a query blocks the input for its run
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action == rgmi_pkg::ACT_QUERY) |=> !in_ready)
		else $error("input taken during a query");

	// a load word leaves the core ready
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (action != rgmi_pkg::ACT_QUERY) |=> in_ready)
		else $error("load word stalled the core");
`endif

endmodule

### test/tb_rectilinear_grid_multilinear_interp.sv
`timescale 1ns / 100ps
// tb_rectilinear_grid_multilinear_interp: self-checking bench of the grid interpolator
// loads coordinates and node values, fires queries and checks them against a local
// predictor of the search and fixed-point lerps; depends on rgmi_pkg and the top level
module tb_rectilinear_grid_multilinear_interp;

	localparam int AXIS_POINTS = 16;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  act;
		logic [1:0]  ax;
		logic [11:0] idx;
		logic [31:0] data;
		logic [31:0] p0, p1, p2;
		logic        has_exp;
		logic [31:0] exp_val;
		rgmi_pkg::res_t exp_st;
	} stim_t;

	typedef struct {
		logic [31:0] val;
		rgmi_pkg::res_t st;
	} result_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [4:0] cfg_data;
	logic in_valid, in_ready;
	logic [1:0] action, axis_sel;
	logic [11:0] entry_index;
	logic signed [31:0] load_data, point_0, point_1, point_2;
	logic out_valid, out_ready;
	logic signed [31:0] interp_value;
	logic [1:0] status;

	rectilinear_grid_multilinear_interp DUT (.*);

	// predictor state
	logic [1:0]  grid_dims;
	logic [4:0]  grid_len [3];
	logic signed [31:0] coord_mem [48];
	logic signed [31:0] node_mem [4096];

	result_t pending_results [$];
	int errors = 0;
	int n_query = 0, n_ok = 0, n_outside = 0, n_zw = 0;
	bit out_idle_on = 1;

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	initial begin
		#50ms;
		$display("Mismatches found");
		$finish;
	end

	function automatic int eff_len(int d);
		int n;
		n = grid_len[d];
		if (n < 2) n = 2;
		if (n > AXIS_POINTS) n = AXIS_POINTS;
		return n;
	endfunction

	function automatic int eff_dims();
		return (grid_dims == 0) ? 1 : int'(grid_dims);
	endfunction

	// node count reachable by the shape in use
	function automatic int node_need();
		int n, d;
		n = 1;
		for (d = 0; d < eff_dims(); d++) n = n * eff_len(d);
		return n;
	endfunction

	function automatic longint floor16(longint n);
		if (n >= 0) return n / 65536;
		return -((-n + 65535) / 65536);
	endfunction

	// result of one query point on the current grid
	function automatic result_t interpolate(logic signed [31:0] pt [3]);
		result_t r;
		int dims, lo, hi, mid, d, k, fl;
		int pos [3];
		int stride [3];
		longint x0, dx, q;
		longint tt [3];
		longint c [8];
		dims = eff_dims();
		r.val = '0;
		// interval search on each axis
		for (d = 0; d < dims; d++) begin
			lo = 0; hi = eff_len(d) - 1;
			if (pt[d] < coord_mem[d*16+lo] || pt[d] > coord_mem[d*16+hi]) begin
				r.st = rgmi_pkg::RES_OUTSIDE;
				return r;
			end
			while (hi > lo + 1) begin
				mid = (lo + hi) / 2;
				if (pt[d] > coord_mem[d*16+mid]) lo = mid;
				else hi = mid;
			end
			pos[d] = lo;
		end
		// interpolation weights
		for (d = 0; d < dims; d++) begin
			x0 = coord_mem[d*16+pos[d]];
			dx = longint'(coord_mem[d*16+pos[d]+1]) - x0;
			if (dx == 0) begin
				r.st = rgmi_pkg::RES_ZERO_WIDTH;
				return r;
			end
			q = ((longint'(pt[d]) - x0) * 65536) / dx;
			if (q < 0) q = 0;
			if (q > 65536) q = 65536;
			tt[d] = q;
		end
		for (d = 0; d < 3; d++) stride[d] = 1;
		for (d = dims - 2; d >= 0; d--) stride[d] = stride[d+1] * eff_len(d+1);
		for (k = 0; k < (1 << dims); k++) begin
			fl = 0;
			for (d = 0; d < dims; d++) fl += (pos[d] + ((k >> d) & 1)) * stride[d];
			c[k] = (fl < rgmi_pkg::NODE_DEPTH) ? longint'(node_mem[fl]) : 0;
		end
		for (d = dims - 1; d >= 0; d--)
			for (k = 0; k < (1 << d); k++)
				c[k] = c[k] + floor16((c[k | (1 << d)] - c[k]) * tt[d] + 32768);
		if (c[0] > 64'sd2147483647) c[0] = 64'sd2147483647;
		if (c[0] < -64'sd2147483648) c[0] = -64'sd2147483648;
		r.val = c[0][31:0];
		r.st = rgmi_pkg::RES_OK;
		return r;
	endfunction

	// random idle cycles on the input side
	task automatic idle_gap(bit allow);
		if (!allow) return;
		if ($urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 21);
		end
	endtask

	// hold the input until every expected result has come
	task automatic wait_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_reg(logic [1:0] ri, logic [4:0] v);
		cfg_valid <= 1'b1; cfg_index <= ri; cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		if (ri == rgmi_pkg::CFG_NUM_DIMS) grid_dims = v[1:0];
		else grid_len[ri - 1] = v;
	endtask

	// drain, settle, then reprogram the grid shape
	task automatic set_shape(logic [4:0] nd, logic [4:0] l0, logic [4:0] l1, logic [4:0] l2);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		write_reg(rgmi_pkg::CFG_NUM_DIMS, nd);
		write_reg(rgmi_pkg::CFG_LEN_AXIS0, l0);
		write_reg(rgmi_pkg::CFG_LEN_AXIS1, l1);
		write_reg(rgmi_pkg::CFG_LEN_AXIS2, l2);
		cfg_valid <= 1'b0;
	endtask

	// send one word; update predictor on acceptance
	task automatic send_word(stim_t s, bit gaps);
		logic signed [31:0] pt [3];
		result_t r;
		idle_gap(gaps);
		in_valid <= 1'b1; action <= s.act; axis_sel <= s.ax; entry_index <= s.idx;
		load_data <= s.data; point_0 <= s.p0; point_1 <= s.p1; point_2 <= s.p2;
		do @(posedge clk); while (!in_ready);
		case (s.act)
			rgmi_pkg::ACT_LOAD_COORD: if (s.ax < 3 && s.idx < AXIS_POINTS)
				coord_mem[s.ax*16+s.idx] = s.data;
			rgmi_pkg::ACT_LOAD_NODE: node_mem[s.idx] = s.data;
			rgmi_pkg::ACT_QUERY: begin
				pt[0] = s.p0; pt[1] = s.p1; pt[2] = s.p2;
				r = interpolate(pt);
				if (s.has_exp && (r.val !== s.exp_val || r.st !== s.exp_st)) begin
					$error("table row expectation disagrees with predictor");
					errors++;
				end
				pending_results.push_back(r);
				n_query++;
			end
			default: ;
		endcase
	endtask

	// result checker
	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (interp_value !== e.val) begin
					$error("interp_value expected %h actual %h", e.val, interp_value);
					errors++;
				end
				if (status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, status);
					errors++;
				end
				case (e.st)
					rgmi_pkg::RES_OK: n_ok++;
					rgmi_pkg::RES_OUTSIDE: n_outside++;
					default: n_zw++;
				endcase
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (!arst_n) out_ready <= 1'b0;
		else out_ready <= out_idle_on ? ($urandom_range(99) >= 21) : 1'b1;
	end

	function automatic stim_t mk(logic [1:0] a, logic [1:0] ax, logic [11:0] i, logic [31:0] dta);
		stim_t s;
		s.act = a; s.ax = ax; s.idx = i; s.data = dta;
		s.p0 = $urandom; s.p1 = $urandom; s.p2 = $urandom;
		s.has_exp = 1'b0; s.exp_val = '0; s.exp_st = rgmi_pkg::RES_OK;
		return s;
	endfunction

	function automatic stim_t mkq(logic [31:0] a, logic [31:0] b, logic [31:0] c2,
			logic he, logic [31:0] ev, rgmi_pkg::res_t es);
		stim_t s;
		s = mk(rgmi_pkg::ACT_QUERY, 2'($urandom), 12'($urandom), $urandom);
		s.p0 = a; s.p1 = b; s.p2 = c2;
		s.has_exp = he; s.exp_val = ev; s.exp_st = es;
		return s;
	endfunction

	// random nondecreasing axis with an occasional repeated coordinate
	task automatic load_axes(bit gaps, bit extremes);
		int d, j;
		logic signed [31:0] v;
		for (d = 0; d < 3; d++) begin
			v = extremes ? 32'sh8000_0000 : -$signed(32'($urandom_range(200000)));
			for (j = 0; j < AXIS_POINTS; j++) begin
				if (extremes && j == AXIS_POINTS - 1) v = 32'sh7fff_ffff;
				send_word(mk(rgmi_pkg::ACT_LOAD_COORD, 2'(d), 12'(j), v), gaps);
				if ($urandom_range(19) != 0) v = v + $signed(32'($urandom_range(1, 90000)));
			end
		end
	endtask

	// node values for every flat index the shape can reach
	task automatic load_nodes(int cnt, bit gaps);
		int i;
		logic [31:0] v;
		for (i = 0; i < cnt; i++) begin
			case ($urandom_range(3))
				0: v = 32'h7fff_ffff;
				1: v = 32'h8000_0000;
				default: v = $urandom;
			endcase
			send_word(mk(rgmi_pkg::ACT_LOAD_NODE, 2'($urandom), 12'(i), v), gaps);
		end
	endtask

	function automatic logic [31:0] rand_point(int d);
		int j;
		logic signed [31:0] a, b;
		j = $urandom_range(eff_len(d) - 2);
		a = coord_mem[d*16+j]; b = coord_mem[d*16+j+1];
		case ($urandom_range(9))
			0: return $urandom;
			1: return a;
			2: return coord_mem[d*16+eff_len(d)-1];
			3: return coord_mem[d*16] - 1;
			default: return a + $signed(32'($urandom_range(0,
				(b > a && longint'(b) - a < 64'd1000000) ? int'(b - a) : 0)));
		endcase
	endfunction

	task automatic run_queries(int cnt, bit gaps);
		int i;
		stim_t s;
		for (i = 0; i < cnt; i++) begin
			case ($urandom_range(19))
				0: s = mk(ACT_UNUSED, 2'($urandom), 12'($urandom), $urandom);
				1: s = mk(rgmi_pkg::ACT_LOAD_COORD, 2'($urandom_range(3)), 12'($urandom),
					$urandom);
				default: s = mkq(rand_point(0), rand_point(1), rand_point(2), 1'b0, '0,
					rgmi_pkg::RES_OK);
			endcase
			// a coordinate rewrite that would land in range is moved out of range, so the axes keep their order
			if (s.act == rgmi_pkg::ACT_LOAD_COORD && s.ax < 3 && s.idx < AXIS_POINTS)
				s.idx = s.idx + 12'd16;
			send_word(s, gaps);
		end
	endtask

	stim_t directed [$];

	initial begin
		int i;
		arst_n = 1'b0; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0; action = '0; axis_sel = '0; entry_index = '0;
		load_data = '0; point_0 = '0; point_1 = '0; point_2 = '0;
		grid_dims = 2'd1; grid_len[0] = 5'd16; grid_len[1] = 5'd16; grid_len[2] = 5'd16;
		for (i = 0; i < 48; i++) coord_mem[i] = '0;
		for (i = 0; i < 4096; i++) node_mem[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full-range axes, extreme nodes, then a table of loads, an unused action and queries
		set_shape(5'd3, 5'd2, 5'd2, 5'd2);
		load_axes(1'b0, 1'b1);
		load_nodes(8, 1'b0);
		directed.push_back(mk(rgmi_pkg::ACT_LOAD_NODE, 2'd0, 12'd0, 32'h7fff_ffff));
		directed.push_back(mk(rgmi_pkg::ACT_LOAD_NODE, 2'd0, 12'd1, 32'h8000_0000));
		directed.push_back(mk(rgmi_pkg::ACT_LOAD_COORD, 2'd3, 12'd0, 32'h1234_5678));
		directed.push_back(mk(rgmi_pkg::ACT_LOAD_COORD, 2'd0, 12'd4095, 32'h1234_5678));
		directed.push_back(mk(ACT_UNUSED, 2'd0, 12'd0, 32'hdead_beef));
		directed.push_back(mkq(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0,
			rgmi_pkg::RES_OK));
		directed.push_back(mkq(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, '0,
			rgmi_pkg::RES_OK));
		directed.push_back(mkq(32'h0, 32'h0, 32'h0, 1'b0, '0, rgmi_pkg::RES_OK));
		directed.push_back(mkq(32'h0001_0000, 32'hffff_0000, 32'h5555_aaaa, 1'b0, '0,
			rgmi_pkg::RES_OK));
		foreach (directed[k]) send_word(directed[k], 1'b0);

		// one axis, zero-width interval and outside points
		set_shape(5'd0, 5'd1, 5'd31, 5'd31);
		send_word(mk(rgmi_pkg::ACT_LOAD_COORD, 2'd0, 12'd0, 32'h0000_1000), 1'b0);
		send_word(mk(rgmi_pkg::ACT_LOAD_COORD, 2'd0, 12'd1, 32'h0000_1000), 1'b0);
		send_word(mkq(32'h0000_1000, $urandom, $urandom, 1'b1, '0, rgmi_pkg::RES_ZERO_WIDTH),
			1'b0);
		send_word(mkq(32'h0000_0fff, $urandom, $urandom, 1'b1, '0, rgmi_pkg::RES_OUTSIDE),
			1'b0);
		send_word(mkq(32'h0000_1001, $urandom, $urandom, 1'b1, '0, rgmi_pkg::RES_OUTSIDE),
			1'b0);
		send_word(mk(rgmi_pkg::ACT_LOAD_COORD, 2'd0, 12'd1, 32'h0001_1000), 1'b0);
		send_word(mkq(32'h0001_1000, $urandom, $urandom, 1'b0, '0, rgmi_pkg::RES_OK), 1'b0);

		// random phases over several shapes; nodes cover the flattened range in use
		for (i = 0; i < 7; i++) begin
			case (i)
				0: set_shape(5'd1, 5'd16, 5'd31, 5'd0);
				1: set_shape(5'd2, 5'd16, 5'd16, 5'd2);
				2: set_shape(5'd3, 5'd16, 5'd4, 5'd3);
				3: set_shape(5'd3, 5'd2, 5'd3, 5'd31);
				4: set_shape(5'd2, 5'd0, 5'd5, 5'd9);
				5: set_shape(5'd3, 5'($urandom_range(2, 5)), 5'($urandom_range(2, 5)),
					5'($urandom_range(2, 5)));
				default: set_shape(5'd1, 5'd7, 5'd2, 5'd2);
			endcase
			out_idle_on = (i != 2);
			load_axes(i != 2, i == 4);
			load_nodes(node_need(), i != 2);
			if (i == 1) begin
				// pause the sender midway until every result is back
				run_queries(30, 1'b1);
				wait_drain();
				run_queries(30, 1'b1);
			end else begin
				run_queries(60, i != 2);
			end
		end

		wait_drain();
		repeat (300) @(posedge clk);
		$display("ran %0d queries: %0d ok, %0d outside, %0d zero-width over 9 grid shapes",
			n_query, n_ok, n_outside, n_zw);
		if (errors == 0 && pending_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
